FILE: src/tfa_pkg.sv
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared types and constants for the TCP flow table with aging.
// ----------------------------------------------------------------------------
package tfa_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int BYTES_W    = 32;
    localparam int HEAD_W     = 56;
    localparam int HEAD_LEN_W = 3;
    localparam int TIME_W     = 32;
    localparam int EXPIRE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int EXP_CNT_W  = 7;

    // Stream word widths
    localparam int S_DATA_W = 256;
    localparam int M_DATA_W = 80;

    // Expiry register reset value
    localparam logic [EXPIRE_W-1:0] EXPIRE_RESET = 16'd60;

    // Saturation point of the aging counter
    localparam logic [EXP_CNT_W-1:0] EXP_CNT_MAX = '1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UPDATED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    // Payload prefixes, first byte in the top bits
    localparam logic [55:0] HEAD_HTTP = 56'h485454502F312E;  // "HTTP/1."
    localparam logic [23:0] HEAD_GET  = 24'h474554;          // "GET"
    localparam logic [31:0] HEAD_POST = 32'h504F5354;        // "POST"

    // One stored flow entry
    typedef struct packed {
        logic [2*ADDR_W-1:0] addrs;     // client addr high, server addr low
        logic [2*PORT_W-1:0] ports;     // client port high, server port low
        logic                binary;
        logic [TIME_W-1:0]   created;
        logic [BYTES_W-1:0]  sent;
        logic [BYTES_W-1:0]  received;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: src/tfa_ram.sv
// ----------------------------------------------------------------------------
// tfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tfa_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tfa_classify.sv
// ----------------------------------------------------------------------------
// tfa_classify
// HTTP prefix classifier on the first payload bytes.
// ----------------------------------------------------------------------------
module tfa_classify (
    input  logic [tfa_pkg::HEAD_W-1:0]     i_head,
    input  logic [tfa_pkg::HEAD_LEN_W-1:0] i_head_len,
    output logic                           o_is_http
);
    import tfa_pkg::*;

    logic m_http;
    logic m_get;
    logic m_post;

    // Match each prefix only when enough bytes are present
    assign m_http = (i_head_len >= HEAD_LEN_W'(7)) && (i_head == HEAD_HTTP);
    assign m_get  = (i_head_len >= HEAD_LEN_W'(3)) && (i_head[55:32] == HEAD_GET);
    assign m_post = (i_head_len >= HEAD_LEN_W'(4)) && (i_head[55:24] == HEAD_POST);

    assign o_is_http = m_http | m_get | m_post;

endmodule

FILE: src/tcp_flow_table_with_aging.sv
// ----------------------------------------------------------------------------
// tcp_flow_table_with_aging
// Flow table keyed by the TCP 4-tuple, with byte counters and age-out.
//
//  Channel   Dir  Handshake                    Word
//  s_axis    in   s_axis_tvalid/tready         one stream event
//  m_axis    out  m_axis_tvalid/tready         one result per event
//  cfg       in   i_cfg_wr_en                  expire_seconds
//
// An event sweeps the table RAM, reading every entry, one per cycle,
// matching the key, finding the lowest free slot and marking entries that
// age out; then the commit state writes the new or updated entry and clears
// the aged valid bits, except for an event that hits a binary flow.
// Reset clears the valid bits at once; entry data needs no clearing.
// A result waiting in the output register does not block the next event.
// ----------------------------------------------------------------------------
module tcp_flow_table_with_aging (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_wr_en,
    input  logic [tfa_pkg::EXPIRE_W-1:0]   i_cfg_wr_data,
    // Event stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // client address, client port, server address, server port, client bytes,
    // server bytes, payload head, payload head length, now seconds, zero pad
    input  logic [tfa_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, is_http, total_sent, total_received, expired_count, zero pad
    output logic [tfa_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import tfa_pkg::*;

    // State codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [EXPIRE_W-1:0]     r_expire;

    // Latched event
    logic [2*ADDR_W-1:0]     r_key_addrs;
    logic [2*PORT_W-1:0]     r_key_ports;
    logic [BYTES_W-1:0]      r_cbytes;
    logic [BYTES_W-1:0]      r_sbytes;
    logic [HEAD_W-1:0]       r_head;
    logic [HEAD_LEN_W-1:0]   r_head_len;
    logic [TIME_W-1:0]       r_now;

    // Sweep bookkeeping
    logic [TABLE_DEPTH-1:0]  r_valid;
    logic [TABLE_DEPTH-1:0]  r_age_mask;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_cmp_vld;
    logic                    r_cmp_live;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_hit_found;
    logic [IDX_W-1:0]        r_hit_idx;
    logic                    r_hit_bin;
    logic [TIME_W-1:0]       r_hit_created;
    logic [BYTES_W-1:0]      r_hit_sent;
    logic [BYTES_W-1:0]      r_hit_recv;
    logic                    r_free_found;
    logic [IDX_W-1:0]        r_free_idx;
    logic [EXP_CNT_W-1:0]    r_exp_cnt;

    // Pending result and output register
    logic [STATUS_W-1:0]     r_res_status;
    logic                    r_res_http;
    logic [BYTES_W-1:0]      r_res_sent;
    logic [BYTES_W-1:0]      r_res_recv;
    logic [EXP_CNT_W-1:0]    r_res_exp;
    logic                    r_out_vld;
    logic [STATUS_W-1:0]     r_out_status;
    logic                    r_out_http;
    logic [BYTES_W-1:0]      r_out_sent;
    logic [BYTES_W-1:0]      r_out_recv;
    logic [EXP_CNT_W-1:0]    r_out_exp;

    // RAM interface
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    t_entry                  ram_wdata;
    logic                    ram_re;
    t_entry                  ram_rdata;

    logic                    s_accept;
    logic                    out_free;
    logic                    is_http;
    logic                    cmp_key_eq;
    logic                    cmp_aged;
    logic [TIME_W:0]         cmp_deadline;
    logic                    sweep_last;
    logic                    do_ignore;
    logic                    do_update;
    logic                    do_insert;
    logic [BYTES_W-1:0]      sum_sent;
    logic [BYTES_W-1:0]      sum_recv;
    logic [TABLE_DEPTH-1:0]  ins_mask;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_vld | m_axis_tready;
    assign sweep_last    = (r_rd_idx == IDX_W'(TABLE_DEPTH - 1));

    // Table memory
    tfa_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // Payload classifier
    tfa_classify u_classify (
        .i_head     (r_head),
        .i_head_len (r_head_len),
        .o_is_http  (is_http)
    );

    // Expiry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire <= EXPIRE_RESET;
        end else if (i_cfg_wr_en) begin
            r_expire <= i_cfg_wr_data;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_accept) n_state = ST_SWEEP;
            ST_SWEEP:  if (sweep_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_RESULT;
            ST_RESULT: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the event word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key_addrs <= {s_axis_tdata[31:0], s_axis_tdata[79:48]};
            r_key_ports <= {s_axis_tdata[47:32], s_axis_tdata[95:80]};
            r_cbytes    <= s_axis_tdata[127:96];
            r_sbytes    <= s_axis_tdata[159:128];
            r_head      <= s_axis_tdata[215:160];
            r_head_len  <= s_axis_tdata[218:216];
            r_now       <= s_axis_tdata[250:219];
        end
    end

    // Read address counter
    assign ram_re = (r_state == ST_SWEEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= ram_re;
            if (s_accept) begin
                r_rd_idx <= '0;
            end else if (ram_re && !sweep_last) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
        end
    end

    // Compare the entry read in the previous cycle
    assign cmp_key_eq   = (ram_rdata.addrs == r_key_addrs) && (ram_rdata.ports == r_key_ports);
    assign cmp_deadline = {1'b0, ram_rdata.created} + (TIME_W + 1)'(r_expire);
    assign cmp_aged     = (cmp_deadline < {1'b0, r_now});

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_cmp_live <= r_valid[r_rd_idx];
            r_cmp_idx  <= r_rd_idx;
        end
    end

    // Track first hit, first free slot and aged entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_age_mask   <= '0;
            r_exp_cnt    <= '0;
        end else if (s_accept) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_age_mask   <= '0;
            r_exp_cnt    <= '0;
        end else begin
            if (ram_re && !r_valid[r_rd_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (r_cmp_vld && r_cmp_live) begin
                if (cmp_key_eq && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                end
                if (cmp_aged) begin
                    r_age_mask[r_cmp_idx] <= 1'b1;
                    if (r_exp_cnt != EXP_CNT_MAX) begin
                        r_exp_cnt <= r_exp_cnt + EXP_CNT_W'(1);
                    end
                end
            end
        end
    end

    // Capture the hit entry and the free index
    always_ff @(posedge i_clk) begin
        if (ram_re && !r_valid[r_rd_idx] && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (r_cmp_vld && r_cmp_live && cmp_key_eq && !r_hit_found) begin
            r_hit_idx     <= r_cmp_idx;
            r_hit_bin     <= ram_rdata.binary;
            r_hit_created <= ram_rdata.created;
            r_hit_sent    <= ram_rdata.sent;
            r_hit_recv    <= ram_rdata.received;
        end
    end

    // Commit decisions
    assign do_ignore = r_hit_found & r_hit_bin;
    assign do_update = r_hit_found & ~r_hit_bin;
    assign do_insert = ~r_hit_found & r_free_found;
    assign sum_sent  = r_hit_sent + r_cbytes;
    assign sum_recv  = r_hit_recv + r_sbytes;

    always_comb begin
        ins_mask = '0;
        ins_mask[r_free_idx] = 1'b1;
    end

    // Write back the updated or new entry
    always_comb begin
        ram_we          = (r_state == ST_COMMIT) && (do_update || do_insert);
        ram_waddr       = do_update ? r_hit_idx : r_free_idx;
        ram_wdata.addrs = r_key_addrs;
        ram_wdata.ports = r_key_ports;
        if (do_update) begin
            ram_wdata.binary   = r_hit_bin;
            ram_wdata.created  = r_hit_created;
            ram_wdata.sent     = sum_sent;
            ram_wdata.received = sum_recv;
        end else begin
            ram_wdata.binary   = ~is_http;
            ram_wdata.created  = r_now;
            ram_wdata.sent     = r_cbytes;
            ram_wdata.received = r_sbytes;
        end
    end

    // Valid bits: drop aged entries, then insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == ST_COMMIT && !do_ignore) begin
            if (do_insert) begin
                r_valid <= (r_valid & ~r_age_mask) | ins_mask;
            end else begin
                r_valid <= r_valid & ~r_age_mask;
            end
        end
    end

    // Form the result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COMMIT) begin
            priority if (do_ignore) begin
                r_res_status <= STAT_IGNORED;
                r_res_http   <= 1'b0;
                r_res_sent   <= r_hit_sent;
                r_res_recv   <= r_hit_recv;
                r_res_exp    <= '0;
            end else if (do_update) begin
                r_res_status <= STAT_UPDATED;
                r_res_http   <= is_http;
                r_res_sent   <= sum_sent;
                r_res_recv   <= sum_recv;
                r_res_exp    <= r_exp_cnt;
            end else if (do_insert) begin
                r_res_status <= STAT_ADDED;
                r_res_http   <= is_http;
                r_res_sent   <= r_cbytes;
                r_res_recv   <= r_sbytes;
                r_res_exp    <= r_exp_cnt;
            end else begin
                r_res_status <= STAT_FULL;
                r_res_http   <= is_http;
                r_res_sent   <= '0;
                r_res_recv   <= '0;
                r_res_exp    <= r_exp_cnt;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_RESULT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT && out_free) begin
            r_out_status <= r_res_status;
            r_out_http   <= r_res_http;
            r_out_sent   <= r_res_sent;
            r_out_recv   <= r_res_recv;
            r_out_exp    <= r_res_exp;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_exp, r_out_recv, r_out_sent, r_out_http, r_out_status};

`ifndef NO_ASSERTIONS
    // Table writes happen only in the commit cycle
    a_write_in_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_COMMIT))
        else $error("table write outside commit");

    // An ignored event ages nothing
    a_ignore_no_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && do_ignore) |=> $stable(r_valid))
        else $error("valid bits changed on an ignored event");

    // A new entry is valid after commit
    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && do_insert) |=> (r_valid[r_free_idx] == 1'b1))
        else $error("inserted entry not valid");

    // An ignored result never reports aged entries
    a_ignore_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == STAT_IGNORED) |-> (r_out_exp == '0))
        else $error("ignored result with nonzero aged count");
`endif

endmodule

FILE: test/tcp_flow_table_with_aging_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_table_with_aging_test
// Self-checking bench for the TCP flow table. A driver feeds stream events
// from a queue and a monitor checks every result word against a bench-side
// flow table model that tracks inserts, byte counters, binary flows, the
// table-full case and the aging sweep, across several expiry settings and
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tcp_flow_table_with_aging_test;
    import tfa_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 80;
    localparam int KEY_POOL     = 80;

    // Flow keys: client addr, client port, server addr, server port
    localparam logic [95:0] KEY_A    = {32'h0A000001, 16'd40000, 32'hC0A80001, 16'd80};
    localparam logic [95:0] KEY_B    = {32'h0A000001, 16'd40001, 32'hC0A80001, 16'd80};
    localparam logic [95:0] KEY_C    = {32'h0A000002, 16'd51000, 32'hC0A80002, 16'd8080};
    localparam logic [95:0] KEY_D    = {32'h0A000003, 16'd52000, 32'hC0A80001, 16'd443};
    localparam logic [95:0] KEY_E    = {32'h0A000004, 16'd53000, 32'hC0A80003, 16'd22};
    localparam logic [95:0] KEY_F    = {32'h0A000005, 16'd54000, 32'hC0A80001, 16'd80};
    localparam logic [95:0] KEY_G    = {32'h0A000006, 16'd55000, 32'hC0A80004, 16'd80};
    localparam logic [95:0] KEY_H    = {32'h0A000007, 16'd56000, 32'hC0A80005, 16'd80};
    localparam logic [95:0] KEY_ZERO = '0;
    localparam logic [95:0] KEY_ONES = '1;

    // Payload heads, first byte in the top bits
    localparam logic [HEAD_W-1:0] HEAD_GET_X   = {HEAD_GET, 32'h202F7820};
    localparam logic [HEAD_W-1:0] HEAD_POST_0  = {HEAD_POST, 24'h000000};
    localparam logic [HEAD_W-1:0] HEAD_POST_1  = {HEAD_POST, 24'hFFFFFF};
    localparam logic [HEAD_W-1:0] HEAD_SLASH   = HEAD_HTTP ^ 56'h1;  // "HTTP/1/"
    localparam logic [HEAD_W-1:0] HEAD_NOISE   = 56'h00112233445566;

    typedef struct {
        logic [ADDR_W-1:0]     cli_ip;
        logic [PORT_W-1:0]     cli_tcp;
        logic [ADDR_W-1:0]     srv_ip;
        logic [PORT_W-1:0]     srv_tcp;
        logic [BYTES_W-1:0]    client_bytes;
        logic [BYTES_W-1:0]    server_bytes;
        logic [HEAD_W-1:0]     payload_head;
        logic [HEAD_LEN_W-1:0] payload_head_len;
        logic [TIME_W-1:0]     now_seconds;
    } t_flow_event;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic                 is_http;
        logic [BYTES_W-1:0]   total_sent;
        logic [BYTES_W-1:0]   total_received;
        logic [EXP_CNT_W-1:0] expired_count;
    } t_flow_result;

    // DUT connections
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [EXPIRE_W-1:0]   i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    // Bench-side flow table
    logic                  tbl_live [TABLE_DEPTH];
    logic [2*ADDR_W-1:0]   tbl_addrs [TABLE_DEPTH];
    logic [2*PORT_W-1:0]   tbl_ports [TABLE_DEPTH];
    logic                  tbl_binary [TABLE_DEPTH];
    logic [TIME_W-1:0]     tbl_created [TABLE_DEPTH];
    logic [BYTES_W-1:0]    tbl_sent [TABLE_DEPTH];
    logic [BYTES_W-1:0]    tbl_received [TABLE_DEPTH];
    logic [EXPIRE_W-1:0]   expire_secs = EXPIRE_RESET;

    // Stimulus and checking state
    t_flow_event           event_queue[$];
    t_flow_result          result_queue[$];
    t_flow_event           offered_event;
    t_flow_result          predicted_result;
    t_flow_result          seen_result;
    t_flow_result          due_result;
    logic [ADDR_W-1:0]     pool_caddr [KEY_POOL];
    logic [PORT_W-1:0]     pool_cport [KEY_POOL];
    logic [ADDR_W-1:0]     pool_saddr [KEY_POOL];
    logic [PORT_W-1:0]     pool_sport [KEY_POOL];
    logic [TIME_W-1:0]     sim_now = 32'd5000;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    hold_req  = 0;
    int                    hold_ack  = 0;
    int                    hold_left = 0;
    int                    fail_count = 0;
    int                    events_accepted = 0;
    int                    status_seen [4] = '{0, 0, 0, 0};
    int                    max_expired = 0;

    tcp_flow_table_with_aging u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Build an event from a 96-bit flow key
    function automatic t_flow_event make_event(input logic [95:0] key,
                                               input logic [31:0] cbytes,
                                               input logic [31:0] sbytes,
                                               input logic [HEAD_W-1:0] head,
                                               input logic [HEAD_LEN_W-1:0] hlen,
                                               input logic [TIME_W-1:0] now);
        t_flow_event ev;
        {ev.cli_ip, ev.cli_tcp, ev.srv_ip, ev.srv_tcp} = key;
        ev.client_bytes     = cbytes;
        ev.server_bytes     = sbytes;
        ev.payload_head     = head;
        ev.payload_head_len = hlen;
        ev.now_seconds      = now;
        return ev;
    endfunction

    // Append an event to the pending queue
    function automatic void add_event(input t_flow_event ev);
        event_queue = {event_queue, ev};
    endfunction

    // Pack an event into the input word, first field lowest
    function automatic logic [S_DATA_W-1:0] pack_event(input t_flow_event ev);
        return S_DATA_W'({ev.now_seconds, ev.payload_head_len, ev.payload_head,
                          ev.server_bytes, ev.client_bytes, ev.srv_tcp,
                          ev.srv_ip, ev.cli_tcp, ev.cli_ip});
    endfunction

    // Random event: mostly known keys, a rising clock and real prefixes
    function automatic t_flow_event random_event();
        t_flow_event ev;
        int k;
        int pick;
        k = $urandom_range(KEY_POOL - 1);
        if ($urandom_range(99) < 85) begin
            ev.cli_ip  = pool_caddr[k];
            ev.cli_tcp = pool_cport[k];
            ev.srv_ip  = pool_saddr[k];
            ev.srv_tcp = pool_sport[k];
        end else begin
            ev.cli_ip  = $urandom;
            ev.cli_tcp = 16'($urandom);
            ev.srv_ip  = $urandom;
            ev.srv_tcp = 16'($urandom);
        end
        ev.client_bytes = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1500);
        ev.server_bytes = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1500);
        ev.payload_head = {24'($urandom), $urandom};
        ev.payload_head_len = 3'($urandom_range(7));
        pick = $urandom_range(9);
        unique case (pick)
            0, 1, 2: begin
                ev.payload_head = HEAD_HTTP;
                ev.payload_head_len = ($urandom_range(3) == 0) ? 3'($urandom_range(6, 4))
                                                                : 3'd7;
            end
            3, 4: begin
                ev.payload_head[55:32] = HEAD_GET;
                ev.payload_head_len = 3'($urandom_range(7, 2));
            end
            5: begin
                ev.payload_head[55:24] = HEAD_POST;
                ev.payload_head_len = 3'($urandom_range(7, 3));
            end
            default: ;
        endcase
        // Mostly a slow clock, now and then a jump, rarely a stray timestamp
        pick = $urandom_range(99);
        if (pick == 0) begin
            ev.now_seconds = $urandom;
        end else begin
            if (pick < 4) sim_now += $urandom_range(2000, 40);
            else sim_now += $urandom_range(3);
            ev.now_seconds = sim_now;
        end
        return ev;
    endfunction

    // Look up, classify, insert or update, then age out old flows unless a binary flow was hit
    task automatic apply_event(input t_flow_event ev, output t_flow_result res);
        logic [2*ADDR_W-1:0] addrs;
        logic [2*PORT_W-1:0] ports;
        logic http;
        int hit;
        int free_slot;
        int expired;
        int i;
        addrs = {ev.cli_ip, ev.srv_ip};
        ports = {ev.cli_tcp, ev.srv_tcp};
        hit = -1;
        free_slot = -1;
        expired = 0;
        res = '{default: '0};
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_live[i]) begin
                if (hit < 0 && tbl_addrs[i] == addrs && tbl_ports[i] == ports) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        // Known binary flow: report its counters and skip aging
        if (hit >= 0 && tbl_binary[hit]) begin
            res.status = STAT_IGNORED;
            res.total_sent = tbl_sent[hit];
            res.total_received = tbl_received[hit];
            return;
        end
        http = (ev.payload_head_len >= 3'd7 && ev.payload_head == HEAD_HTTP)
            || (ev.payload_head_len >= 3'd3 && ev.payload_head[55:32] == HEAD_GET)
            || (ev.payload_head_len >= 3'd4 && ev.payload_head[55:24] == HEAD_POST);
        res.is_http = http;
        if (hit >= 0) begin
            tbl_sent[hit] += ev.client_bytes;
            tbl_received[hit] += ev.server_bytes;
            res.total_sent = tbl_sent[hit];
            res.total_received = tbl_received[hit];
            res.status = STAT_UPDATED;
        end else if (free_slot >= 0) begin
            tbl_live[free_slot] = 1'b1;
            tbl_addrs[free_slot] = addrs;
            tbl_ports[free_slot] = ports;
            tbl_binary[free_slot] = !http;
            tbl_created[free_slot] = ev.now_seconds;
            tbl_sent[free_slot] = ev.client_bytes;
            tbl_received[free_slot] = ev.server_bytes;
            res.total_sent = ev.client_bytes;
            res.total_received = ev.server_bytes;
            res.status = STAT_ADDED;
        end else begin
            res.status = STAT_FULL;
        end
        // Aging sweep; the sum is one bit wider so it never wraps
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_live[i] && ({1'b0, tbl_created[i]} + {17'b0, expire_secs})
                               < {1'b0, ev.now_seconds}) begin
                tbl_live[i] = 1'b0;
                if (expired < EXP_CNT_MAX) expired++;
            end
        end
        res.expired_count = EXP_CNT_W'(expired);
    endtask

    // Driver: predict on accept, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_event(offered_event, predicted_result);
                result_queue = {result_queue, predicted_result};
                events_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_event = event_queue.pop_front();
                    s_axis_tdata  <= pack_event(offered_event);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off, counted down in its own process
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                // status, is_http, total_sent, total_received, expired_count
                seen_result.status         = m_axis_tdata[1:0];
                seen_result.is_http        = m_axis_tdata[2];
                seen_result.total_sent     = m_axis_tdata[34:3];
                seen_result.total_received = m_axis_tdata[66:35];
                seen_result.expired_count  = m_axis_tdata[73:67];
                status_seen[seen_result.status]++;
                if (seen_result.expired_count > max_expired)
                    max_expired = seen_result.expired_count;
                if (result_queue.size() == 0) begin
                    $error("result word with no prediction waiting: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    due_result = result_queue.pop_front();
                    if (seen_result.status !== due_result.status) begin
                        $error("status: expected %0d, got %0d",
                               due_result.status, seen_result.status);
                        fail_count++;
                    end
                    if (seen_result.is_http !== due_result.is_http) begin
                        $error("is_http: expected %0d, got %0d",
                               due_result.is_http, seen_result.is_http);
                        fail_count++;
                    end
                    if (seen_result.total_sent !== due_result.total_sent) begin
                        $error("total_sent: expected %0d, got %0d",
                               due_result.total_sent, seen_result.total_sent);
                        fail_count++;
                    end
                    if (seen_result.total_received !== due_result.total_received) begin
                        $error("total_received: expected %0d, got %0d",
                               due_result.total_received, seen_result.total_received);
                        fail_count++;
                    end
                    if (seen_result.expired_count !== due_result.expired_count) begin
                        $error("expired_count: expected %0d, got %0d",
                               due_result.expired_count, seen_result.expired_count);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= hold_ack == hold_req && hold_left == 0
                             && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Wait until every queued word is sent and every result is back
    task automatic settle();
        do @(negedge i_clk);
        while (event_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Reprogram the expiry while idle, then queue a batch of random events
    task automatic run_phase(input logic [EXPIRE_W-1:0] expiry, input int idle_pct,
                             input int stall_pct, input int count, input bit hold_off);
        settle();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= expiry;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        expire_secs = expiry;
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold_off) hold_req++;
        repeat (count) add_event(random_event());
    endtask

    // Run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

    // Main sequence
    initial begin
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) tbl_live[i] = 1'b0;
        // Odd pool keys share the client address of their neighbor
        for (i = 0; i < KEY_POOL; i++) begin
            pool_caddr[i] = (i % 2 == 1) ? pool_caddr[i - 1] : $urandom;
            pool_cport[i] = 16'($urandom);
            pool_saddr[i] = (i % 4 == 3) ? pool_saddr[i - 1] : $urandom;
            pool_sport[i] = (i % 3 == 0) ? 16'd80 : 16'($urandom);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed events under the reset expiry
        add_event(make_event(KEY_A, 32'd100, 32'd0, HEAD_HTTP, 3'd7, 32'd1000));
        add_event(make_event(KEY_A, '1, '1, HEAD_NOISE, 3'd7, 32'd1001));
        add_event(make_event(KEY_B, 32'd5, 32'd7, HEAD_GET_X, 3'd7, 32'd1002));
        add_event(make_event(KEY_C, 32'd0, 32'd300, HEAD_POST_0, 3'd4, 32'd1003));
        // Prefix cut short by the length: binary, then ignored
        add_event(make_event(KEY_D, 32'd1, 32'd1, HEAD_GET_X, 3'd2, 32'd1003));
        add_event(make_event(KEY_D, 32'd9, 32'd9, HEAD_GET_X, 3'd7, 32'd1004));
        add_event(make_event(KEY_E, 32'd0, 32'd0, '1, 3'd0, 32'd1004));
        add_event(make_event(KEY_ZERO, 32'd0, 32'd0, HEAD_HTTP, 3'd6, 32'd1005));
        add_event(make_event(KEY_ONES, '1, '1, HEAD_POST_1, 3'd7, 32'd0));
        add_event(make_event(KEY_F, 32'd20, 32'd20, HEAD_SLASH, 3'd7, 32'd1005));
        // Expiry boundary: equal is kept, one second later is freed
        add_event(make_event(KEY_A, 32'd1, 32'd2, HEAD_NOISE, 3'd7, 32'd1060));
        add_event(make_event(KEY_G, 32'd3, 32'd3, HEAD_GET_X, 3'd3, 32'd1061));
        add_event(make_event(KEY_A, 32'd4, 32'd4, HEAD_HTTP, 3'd7, 32'd1061));
        add_event(make_event(KEY_C, 32'd7, 32'd7, '0, 3'd0, 32'd1061));
        // Top of the clock: no wrap in the expiry sum
        add_event(make_event(KEY_H, 32'd0, 32'd0, HEAD_POST_0, 3'd4, '1));
        add_event(make_event(KEY_G, 32'd1, 32'd1, HEAD_HTTP, 3'd7, '1));
        add_event(make_event(KEY_H, 32'd2, 32'd2, HEAD_NOISE, 3'd7, 32'd5));

        // Random phases across expiry settings and flow-control patterns
        run_phase(16'd1,     0,  0,  110, 1'b0);
        run_phase(16'd1,     64, 0,  150, 1'b0);
        run_phase(16'd65535, 0,  64, 200, 1'b0);
        run_phase(16'd300,   34, 34, 153, 1'b0);
        run_phase(16'd40,    0,  0,  110, 1'b1);
        run_phase(16'($urandom_range(200, 2)), 0, 0, 110, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d events: %0d added, %0d updated, %0d ignored, %0d table full",
                 events_accepted, status_seen[STAT_ADDED], status_seen[STAT_UPDATED],
                 status_seen[STAT_IGNORED], status_seen[STAT_FULL]);
        $display("expiry from 1 to 65535 s, largest aging sweep freed %0d flows", max_expired);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
